// File: src/owcc_pkg.sv
// ----------------------------------------------------------------------------
// owcc_pkg: shared types and constants of the 1-wire command frame checker
// Result, run and code types, frame constants and the crc16 byte update.
// ----------------------------------------------------------------------------
package owcc_pkg;

  // results one transaction can cause at most
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_IDX_W   = 2;
  // default depth of the run queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] CRC_POLY_R   = 16'hC001;
  localparam logic [15:0] CRC_RESIDUE  = 16'hB001;
  localparam logic [7:0]  RELEASE_BYTE = 8'hAA;
  localparam logic [9:0]  HDR_COUNT    = 10'd2;

  // register reset values
  localparam logic       RST_CHECK_CRC = 1'b1;
  localparam logic [7:0] RST_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] RST_START     = 8'h66;
  localparam logic [7:0] RST_NO_REPLY  = 8'hFF;

  typedef enum logic [1:0] {
    REQ_BEGIN    = 2'd0,
    REQ_PRESENCE = 2'd1,
    REQ_PAYLOAD  = 2'd2,
    REQ_RX_BYTE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_CHECK_CRC = 2'd0,
    CFG_SKIP_ROM  = 2'd1,
    CFG_START     = 2'd2,
    CFG_NO_REPLY  = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ACT_RESET = 3'd0,
    ACT_SEND  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_DELAY = 3'd3,
    ACT_DATA  = 3'd4,
    ACT_DONE  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_DEVICE  = 3'd1,
    ST_SEND_CRC   = 3'd2,
    ST_NO_REPLY   = 3'd3,
    ST_REPLY_CRC  = 3'd4,
    ST_LEN_MISMATCH = 3'd5
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  byte_value;
    logic [9:0]  count;
    status_e     status;
  } result_t;

  // all results caused by one input transaction
  typedef struct packed {
    logic [RES_IDX_W-1:0]             last_idx;
    result_t [MAX_RESULTS-1:0]        res;
  } run_t;

  // crc16 arc, reflected, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  d;
    logic [15:0] c;
    d = b ^ crc[7:0];
    c = {8'h00, crc[15:8]};
    if (^d) begin
      c = c ^ CRC_POLY_R;
    end
    c = c ^ {2'b00, d, 6'b0} ^ {1'b0, d, 7'b0};
    return c;
  endfunction

endpackage

// File: src/owcc_front.sv
// ----------------------------------------------------------------------------
// owcc_front: command sequencer
// Accepts input transactions, tracks the exchange phase and both crc checks,
// and builds the run of results each transaction causes.
// ----------------------------------------------------------------------------
module owcc_front
  import owcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_e        req_type_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  expected_length_i,
  input  logic [9:0]  wait_ms_i,
  input  logic        presence_level_i,
  input  logic [7:0]  data_byte_i,
  output logic        push_o,
  output run_t        run_o
);

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_PRESENCE = 8'b0000_0010,
    PH_PAYLOAD  = 8'b0000_0100,
    PH_SCRC1    = 8'b0000_1000,
    PH_SCRC2    = 8'b0001_0000,
    PH_DUMMY    = 8'b0010_0000,
    PH_LEN      = 8'b0100_0000,
    PH_REPLY    = 8'b1000_0000
  } phase_e;

  function automatic result_t mk(input action_e a, input logic [7:0] b,
                                 input logic [9:0] c, input status_e s);
    result_t r;
    r.action     = a;
    r.byte_value = b;
    r.count      = c;
    r.status     = s;
    return r;
  endfunction

  logic       check_crc_q;
  logic [7:0] skip_rom_q, start_q, no_reply_q;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  pay_rem_q, pay_rem_d;
  logic [7:0]  exp_len_q, exp_len_d;
  logic [9:0]  wait_q, wait_d;
  logic [7:0]  rep_len_q, rep_len_d;
  logic [8:0]  rep_rem_q, rep_rem_d;

  logic        accept;
  logic [2:0]  nres;
  logic [15:0] crc_hdr, crc_b, crc_len;
  logic [7:0]  pay_rem_dec;
  logic [8:0]  rep_rem_dec;

  assign accept      = in_valid_i && in_ready_i;
  assign crc_hdr     = crc_byte(crc_byte(16'h0000, start_q), pay_rem_q);
  assign crc_b       = crc_byte(crc_q, data_byte_i);
  assign crc_len     = crc_byte(16'h0000, data_byte_i);
  assign pay_rem_dec = pay_rem_q - 8'd1;
  assign rep_rem_dec = rep_rem_q - 9'd1;

  // next state and result run
  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    pay_rem_d = pay_rem_q;
    exp_len_d = exp_len_q;
    wait_d    = wait_q;
    rep_len_d = rep_len_q;
    rep_rem_d = rep_rem_q;
    run_o.res = '0;
    nres      = 3'd0;
    case (req_type_i)
      REQ_BEGIN: begin
        pay_rem_d = payload_length_i;
        exp_len_d = expected_length_i;
        wait_d    = wait_ms_i;
        rep_len_d = 8'd0;
        rep_rem_d = 9'd0;
        run_o.res[0] = mk(ACT_RESET, 8'd0, 10'd0, ST_OK);
        nres      = 3'd1;
        phase_d   = PH_PRESENCE;
      end
      REQ_PRESENCE: begin
        if (phase_q == PH_PRESENCE) begin
          if (presence_level_i) begin
            run_o.res[0] = mk(ACT_RESET, 8'd0, 10'd0, ST_OK);
            run_o.res[1] = mk(ACT_DONE, 8'd0, 10'd0, ST_NO_DEVICE);
            nres    = 3'd2;
            phase_d = PH_IDLE;
          end else begin
            run_o.res[0] = mk(ACT_SEND, skip_rom_q, 10'd0, ST_OK);
            run_o.res[1] = mk(ACT_SEND, start_q, 10'd0, ST_OK);
            run_o.res[2] = mk(ACT_SEND, pay_rem_q, 10'd0, ST_OK);
            crc_d = crc_hdr;
            if (pay_rem_q == 8'd0) begin
              run_o.res[3] = mk(ACT_READ, 8'd0, HDR_COUNT, ST_OK);
              nres    = 3'd4;
              phase_d = PH_SCRC1;
            end else begin
              nres    = 3'd3;
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      REQ_PAYLOAD: begin
        if (phase_q == PH_PAYLOAD) begin
          run_o.res[0] = mk(ACT_SEND, data_byte_i, 10'd0, ST_OK);
          crc_d     = crc_b;
          pay_rem_d = pay_rem_dec;
          if (pay_rem_dec == 8'd0) begin
            run_o.res[1] = mk(ACT_READ, 8'd0, HDR_COUNT, ST_OK);
            nres    = 3'd2;
            phase_d = PH_SCRC1;
          end else begin
            nres = 3'd1;
          end
        end
      end
      default: begin
        // byte received from the device
        case (phase_q)
          PH_SCRC1: begin
            crc_d   = crc_b;
            phase_d = PH_SCRC2;
          end
          PH_SCRC2: begin
            crc_d = crc_b;
            if (crc_b != CRC_RESIDUE && check_crc_q) begin
              run_o.res[0] = mk(ACT_RESET, 8'd0, 10'd0, ST_OK);
              run_o.res[1] = mk(ACT_DONE, 8'd0, 10'd0, ST_SEND_CRC);
              nres    = 3'd2;
              phase_d = PH_IDLE;
            end else begin
              // optional release byte and delay, then the reply header
              if (wait_q != 10'd0) begin
                run_o.res[0] = mk(ACT_SEND, RELEASE_BYTE, 10'd0, ST_OK);
                run_o.res[1] = mk(ACT_DELAY, 8'd0, wait_q, ST_OK);
                run_o.res[2] = mk(ACT_READ, 8'd0, HDR_COUNT, ST_OK);
                nres = 3'd3;
              end else begin
                run_o.res[0] = mk(ACT_READ, 8'd0, HDR_COUNT, ST_OK);
                nres = 3'd1;
              end
              phase_d = PH_DUMMY;
            end
          end
          PH_DUMMY: begin
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            rep_len_d = data_byte_i;
            if (data_byte_i == no_reply_q) begin
              run_o.res[0] = mk(ACT_DONE, 8'd0, {2'b00, data_byte_i}, ST_NO_REPLY);
              nres    = 3'd1;
              phase_d = PH_IDLE;
            end else begin
              crc_d     = crc_len;
              rep_rem_d = {1'b0, data_byte_i} + 9'd2;
              run_o.res[0] = mk(ACT_READ, 8'd0, {1'b0, rep_rem_d}, ST_OK);
              nres    = 3'd1;
              phase_d = PH_REPLY;
            end
          end
          PH_REPLY: begin
            crc_d     = crc_b;
            rep_rem_d = rep_rem_dec;
            if (rep_rem_q > 9'd2) begin
              run_o.res[0] = mk(ACT_DATA, data_byte_i, 10'd0, ST_OK);
              nres = 3'd1;
            end
            if (rep_rem_dec == 9'd0) begin
              // reply crc error wins over a length mismatch
              if (crc_b != CRC_RESIDUE) begin
                run_o.res[0] = mk(ACT_DONE, 8'd0, {2'b00, rep_len_q}, ST_REPLY_CRC);
              end else if (exp_len_q != rep_len_q) begin
                run_o.res[0] = mk(ACT_DONE, 8'd0, {2'b00, rep_len_q}, ST_LEN_MISMATCH);
              end else begin
                run_o.res[0] = mk(ACT_DONE, 8'd0, {2'b00, rep_len_q}, ST_OK);
              end
              nres    = 3'd1;
              phase_d = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
    run_o.last_idx = RES_IDX_W'(nres - 3'd1);
  end

  assign push_o = accept && (nres != 3'd0);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_crc_q <= RST_CHECK_CRC;
      skip_rom_q  <= RST_SKIP_ROM;
      start_q     <= RST_START;
      no_reply_q  <= RST_NO_REPLY;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_CHECK_CRC: check_crc_q <= cfg_wdata_i[0];
        CFG_SKIP_ROM:  skip_rom_q  <= cfg_wdata_i;
        CFG_START:     start_q     <= cfg_wdata_i;
        CFG_NO_REPLY:  no_reply_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // exchange state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      crc_q     <= 16'h0000;
      pay_rem_q <= 8'd0;
      exp_len_q <= 8'd0;
      wait_q    <= 10'd0;
      rep_len_q <= 8'd0;
      rep_rem_q <= 9'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      crc_q     <= crc_d;
      pay_rem_q <= pay_rem_d;
      exp_len_q <= exp_len_d;
      wait_q    <= wait_d;
      rep_len_q <= rep_len_d;
      rep_rem_q <= rep_rem_d;
    end
  end

endmodule

// File: src/owcc_queue.sv
// ----------------------------------------------------------------------------
// owcc_queue: run queue
// Short first-in first-out buffer of result runs between front and back.
// ----------------------------------------------------------------------------
module owcc_queue
  import owcc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  run_t                         push_data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output run_t                         head_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   fill_o
);

  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  run_t             entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign fill_o  = fill_q;
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// File: src/owcc_back.sv
// ----------------------------------------------------------------------------
// owcc_back: result serializer
// Hands out the results of the head run one per output transaction.
// ----------------------------------------------------------------------------
module owcc_back
  import owcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  run_t     head_i,
  input  logic     head_valid_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_o,
  output logic     out_last_o
);

  logic [RES_IDX_W-1:0] idx_q;
  logic                 take;

  assign out_valid_o = head_valid_i;
  assign out_o       = head_i.res[idx_q];
  assign out_last_o  = (idx_q == head_i.last_idx);
  assign take        = head_valid_i && out_ready_i;
  assign pop_o       = take && out_last_o;

  // position inside the head run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= out_last_o ? '0 : idx_q + 1'b1;
    end
  end

endmodule

// File: src/onewire_cmd_frame_crc16_checker.sv
// First result: offered the cycle after acceptance when the run queue is empty.
// Throughput: one input transaction per cycle while the run queue has room; results
// leave one per cycle while the output is ready, one output transaction per result.
// The run queue depth (QueueDepth runs) sets how far input can run ahead of output.
// Reset: asynchronous, active low; registers return to defaults, phase idle, queue empty.
// ----------------------------------------------------------------------------
// onewire_cmd_frame_crc16_checker: 1-wire command exchange controller
// Byte-level sequencer with send and reply crc16 checks and a run queue.
// ----------------------------------------------------------------------------
module onewire_cmd_frame_crc16_checker
  import owcc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // payload_length, expected_length, wait_ms, presence_level, data_byte, zero pad
  input  logic [39:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_value, count, status, zero pad
  output logic [23:0] m_axis_tdata,
  // action
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  logic             push, full, pop, empty;
  run_t             run, head;
  result_t          res;
  logic [FillW-1:0] q_fill;

  assign s_axis_tready = !full;

  owcc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_i        (s_axis_tready),
    .req_type_i        (req_e'(s_axis_tuser)),
    .payload_length_i  (s_axis_tdata[7:0]),
    .expected_length_i (s_axis_tdata[15:8]),
    .wait_ms_i         (s_axis_tdata[25:16]),
    .presence_level_i  (s_axis_tdata[26]),
    .data_byte_i       (s_axis_tdata[34:27]),
    .push_o            (push),
    .run_o             (run)
  );

  owcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (run),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .fill_o      (q_fill)
  );

  owcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = res.action;
  assign m_axis_tdata = {3'b000, res.status, res.count, res.byte_value};

`ifndef SYNTHESIS
  // queue never holds more runs than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_fill <= FillW'(QueueDepth))
    else $error("run queue overfilled");

  // a begin command always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_BEGIN) |=> m_axis_tvalid)
    else $error("begin command produced no result");

  // done always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_DONE) |-> m_axis_tlast)
    else $error("done result not last of its run");

  // status is only carried by done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ACT_DONE) |-> (m_axis_tdata[20:18] == ST_OK))
    else $error("status set outside done");
`endif

endmodule

// File: verif/onewire_exchange_monitor.sv
// ----------------------------------------------------------------------------
// onewire_exchange_monitor: result checker for the 1-wire command controller
// Watches the register port and both stream channels, keeps its own model of
// the exchange sequencer and compares every result against it, in order.
// ----------------------------------------------------------------------------
module onewire_exchange_monitor
  import owcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // payload_length, expected_length, wait_ms, presence_level, data_byte, zero pad
  input  logic [39:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_value, count, status, zero pad
  input  logic [23:0] m_axis_tdata,
  // action
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          pending_o,
  output int          fails_o,
  output int          checked_o
);

  // reflected form of the crc16 arc polynomial, for the bit-serial update
  localparam logic [15:0] ARC_POLY_LSB = 16'hA001;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PRESENCE,
    PH_PAYLOAD,
    PH_SCRC_LO,
    PH_SCRC_HI,
    PH_DUMMY,
    PH_LEN,
    PH_REPLY
  } xchg_phase_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] byte_value;
    logic [9:0] count;
    status_e    status;
    logic       last;
  } owire_rsp_t;

  // register copies
  logic       chk_crc;
  logic [7:0] skip_rom;
  logic [7:0] start_byte;
  logic [7:0] no_reply;

  // sequencer state
  xchg_phase_e phase;
  logic [15:0] crc_acc;
  logic [7:0]  pay_left;
  logic [7:0]  exp_len;
  logic [9:0]  wait_q;
  logic [7:0]  rep_len;
  logic [8:0]  rep_left;

  owire_rsp_t step_results[$];
  owire_rsp_t due_results_q[$];
  int         n_fail = 0;
  int         n_checked = 0;

  assign fails_o   = n_fail;
  assign checked_o = n_checked;

  function automatic logic [15:0] crc16_arc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = (r >> 1) ^ ARC_POLY_LSB;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void add_rsp(input action_e a, input logic [7:0] b, input logic [9:0] c,
                                  input status_e s);
    owire_rsp_t r;
    r.action     = a;
    r.byte_value = b;
    r.count      = c;
    r.status     = s;
    r.last       = 1'b0;
    step_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_fail++;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s is %0h, predicted %0h",
                                n_checked, name, got, want));
    end
  endtask

  // results of one accepted input transaction, queued in order
  task automatic step_exchange(input req_e kind, input logic [39:0] d);
    logic [7:0] b;
    status_e    st;
    owire_rsp_t r;
    b = d[34:27];
    step_results.delete();
    case (kind)
      REQ_BEGIN: begin
        pay_left = d[7:0];
        exp_len  = d[15:8];
        wait_q   = d[25:16];
        rep_len  = 8'h00;
        rep_left = 9'd0;
        add_rsp(ACT_RESET, 8'h00, 10'd0, ST_OK);
        phase = PH_PRESENCE;
      end
      REQ_PRESENCE: begin
        if (phase == PH_PRESENCE) begin
          if (d[26]) begin
            // line stayed high: no device
            add_rsp(ACT_RESET, 8'h00, 10'd0, ST_OK);
            add_rsp(ACT_DONE, 8'h00, 10'd0, ST_NO_DEVICE);
            phase = PH_IDLE;
          end else begin
            add_rsp(ACT_SEND, skip_rom, 10'd0, ST_OK);
            add_rsp(ACT_SEND, start_byte, 10'd0, ST_OK);
            add_rsp(ACT_SEND, pay_left, 10'd0, ST_OK);
            crc_acc = crc16_arc_step(16'h0000, start_byte);
            crc_acc = crc16_arc_step(crc_acc, pay_left);
            if (pay_left == 8'h00) begin
              add_rsp(ACT_READ, 8'h00, HDR_COUNT, ST_OK);
              phase = PH_SCRC_LO;
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
      end
      REQ_PAYLOAD: begin
        if (phase == PH_PAYLOAD) begin
          add_rsp(ACT_SEND, b, 10'd0, ST_OK);
          crc_acc  = crc16_arc_step(crc_acc, b);
          pay_left = pay_left - 8'd1;
          if (pay_left == 8'h00) begin
            add_rsp(ACT_READ, 8'h00, HDR_COUNT, ST_OK);
            phase = PH_SCRC_LO;
          end
        end
      end
      REQ_RX_BYTE: begin
        case (phase)
          PH_SCRC_LO: begin
            crc_acc = crc16_arc_step(crc_acc, b);
            phase   = PH_SCRC_HI;
          end
          PH_SCRC_HI: begin
            crc_acc = crc16_arc_step(crc_acc, b);
            if (crc_acc != CRC_RESIDUE && chk_crc) begin
              add_rsp(ACT_RESET, 8'h00, 10'd0, ST_OK);
              add_rsp(ACT_DONE, 8'h00, 10'd0, ST_SEND_CRC);
              phase = PH_IDLE;
            end else begin
              // optional release byte and strong pull-up delay
              if (wait_q != 10'd0) begin
                add_rsp(ACT_SEND, RELEASE_BYTE, 10'd0, ST_OK);
                add_rsp(ACT_DELAY, 8'h00, wait_q, ST_OK);
              end
              add_rsp(ACT_READ, 8'h00, HDR_COUNT, ST_OK);
              phase = PH_DUMMY;
            end
          end
          PH_DUMMY: begin
            phase = PH_LEN;
          end
          PH_LEN: begin
            rep_len = b;
            if (b == no_reply) begin
              add_rsp(ACT_DONE, 8'h00, {2'b00, b}, ST_NO_REPLY);
              phase = PH_IDLE;
            end else begin
              crc_acc  = crc16_arc_step(16'h0000, b);
              rep_left = {1'b0, b} + 9'd2;
              add_rsp(ACT_READ, 8'h00, {1'b0, rep_left}, ST_OK);
              phase = PH_REPLY;
            end
          end
          PH_REPLY: begin
            crc_acc = crc16_arc_step(crc_acc, b);
            // the two trailing crc bytes are not delivered
            if (rep_left > 9'd2) begin
              add_rsp(ACT_DATA, b, 10'd0, ST_OK);
            end
            rep_left = rep_left - 9'd1;
            if (rep_left == 9'd0) begin
              if (crc_acc != CRC_RESIDUE) begin
                st = ST_REPLY_CRC;
              end else if (exp_len != rep_len) begin
                st = ST_LEN_MISMATCH;
              end else begin
                st = ST_OK;
              end
              add_rsp(ACT_DONE, 8'h00, {2'b00, rep_len}, st);
              phase = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    foreach (step_results[i]) begin
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      due_results_q.push_back(r);
    end
  endtask

  // register writes, result comparison and prediction, all on the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    owire_rsp_t e;
    if (!rst_ni) begin
      chk_crc    = RST_CHECK_CRC;
      skip_rom   = RST_SKIP_ROM;
      start_byte = RST_START;
      no_reply   = RST_NO_REPLY;
      phase      = PH_IDLE;
      crc_acc    = 16'h0000;
      pay_left   = 8'h00;
      exp_len    = 8'h00;
      wait_q     = 10'd0;
      rep_len    = 8'h00;
      rep_left   = 9'd0;
      due_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_CHECK_CRC: chk_crc    = cfg_wdata_i[0];
          CFG_SKIP_ROM:  skip_rom   = cfg_wdata_i;
          CFG_START:     start_byte = cfg_wdata_i;
          CFG_NO_REPLY:  no_reply   = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      // output transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (due_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing predicted", n_checked));
        end else begin
          e = due_results_q.pop_front();
          cmp_field("action", 16'(m_axis_tuser), 16'(e.action));
          cmp_field("byte_value", 16'(m_axis_tdata[7:0]), 16'(e.byte_value));
          cmp_field("count", 16'(m_axis_tdata[17:8]), 16'(e.count));
          cmp_field("status", 16'(m_axis_tdata[20:18]), 16'(e.status));
          cmp_field("last", 16'(m_axis_tlast), 16'(e.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_exchange(req_e'(s_axis_tuser), s_axis_tdata);
      end
      pending_o <= due_results_q.size();
    end
  end

endmodule

// File: verif/tb_onewire_cmd_frame_crc16_checker.sv
// ----------------------------------------------------------------------------
// tb_onewire_cmd_frame_crc16_checker: testbench of the 1-wire command controller
// Drives whole command exchanges with good and broken crcs, aborted and noisy
// sequences over several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_onewire_cmd_frame_crc16_checker;
  import owcc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 10;
  localparam int PHASE_ITEMS = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_CHECK_CRC;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_BEGIN;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int pending;
  int fails;
  int checked;

  // register values currently written, for building good frames
  bit         cur_chk = RST_CHECK_CRC;
  logic [7:0] cur_skip = RST_SKIP_ROM;
  logic [7:0] cur_start = RST_START;
  logic [7:0] cur_noreply = RST_NO_REPLY;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_arm = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int rx_gap = 0;
  int cycle_cnt = 0;
  int n_items = 0;
  int n_filler = 0;
  int n_xchg = 0;
  int ex_budget = -1;

  onewire_cmd_frame_crc16_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  onewire_exchange_monitor monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending),
    .fails_o       (fails),
    .checked_o     (checked)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // reset, once
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still predicted", cycle_cnt, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom);
  endfunction

  function automatic logic [39:0] mk_data(input logic [7:0] plen, input logic [7:0] elen,
                                          input logic [9:0] wms, input logic pres,
                                          input logic [7:0] b);
    return {5'b00000, b, pres, wms, elen, plen};
  endfunction

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap        <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        rx_gap <= gap_len();
      end
    end
  end

  // one input transaction; a spent budget cuts the exchange short
  task automatic put_item(input req_e kind, input logic [39:0] data, input bit filler);
    if (ex_budget == 0) begin
      return;
    end
    if (ex_budget > 0) begin
      ex_budget--;
    end
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    if (filler) begin
      n_filler++;
    end else begin
      n_items++;
    end
  endtask

  task automatic put_byte(input req_e kind, input logic [7:0] b);
    put_item(kind, mk_data(rbyte(), rbyte(), 10'($urandom), 1'($urandom), b), 1'b0);
  endtask

  // sometimes slip in a transaction that the current phase must ignore
  task automatic maybe_filler(input req_e k1, input req_e k2);
    req_e kind;
    if ($urandom_range(0, 7) == 0) begin
      kind = $urandom_range(0, 1) ? k1 : k2;
      put_item(kind, mk_data(rbyte(), rbyte(), 10'($urandom), 1'($urandom), rbyte()), 1'b1);
    end
  endtask

  // inverted crc, low byte first; a bad one gets its high byte spoiled
  task automatic put_frame_crc(input logic [15:0] crc, input bit good);
    logic [7:0] hi;
    hi = ~crc[15:8];
    if (!good) begin
      hi = hi ^ 8'($urandom_range(1, 255));
    end
    put_byte(REQ_RX_BYTE, ~crc[7:0]);
    put_byte(REQ_RX_BYTE, hi);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input bit chk, input logic [7:0] skip_v, input logic [7:0] start_v,
                            input logic [7:0] noreply_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CHECK_CRC;
    cfg_wdata_i <= {7'd0, chk};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SKIP_ROM;
    cfg_wdata_i <= skip_v;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_START;
    cfg_wdata_i <= start_v;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NO_REPLY;
    cfg_wdata_i <= noreply_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_chk     = chk;
    cur_skip    = skip_v;
    cur_start   = start_v;
    cur_noreply = noreply_v;
  endtask

  // full command exchange as the device side would answer it
  task automatic run_exchange(input logic [7:0] plen, input logic [7:0] elen,
                              input logic [9:0] wms, input bit absent, input bit scrc_ok,
                              input logic [7:0] rlen, input bit rcrc_ok);
    logic [15:0] crc;
    logic [7:0]  b;
    n_xchg++;
    put_item(REQ_BEGIN, mk_data(plen, elen, wms, 1'($urandom), rbyte()), 1'b0);
    maybe_filler(REQ_PAYLOAD, REQ_RX_BYTE);
    put_item(REQ_PRESENCE, mk_data(rbyte(), rbyte(), 10'($urandom), absent, rbyte()), 1'b0);
    if (absent) begin
      return;
    end
    crc = crc_byte(16'h0000, cur_start);
    crc = crc_byte(crc, plen);
    for (int i = 0; i < int'(plen); i++) begin
      b   = rbyte();
      crc = crc_byte(crc, b);
      maybe_filler(REQ_PRESENCE, REQ_RX_BYTE);
      put_byte(REQ_PAYLOAD, b);
    end
    put_frame_crc(crc, scrc_ok);
    if (!scrc_ok && cur_chk) begin
      return;
    end
    // dummy byte, then the length byte
    maybe_filler(REQ_PRESENCE, REQ_PAYLOAD);
    put_byte(REQ_RX_BYTE, rbyte());
    put_byte(REQ_RX_BYTE, rlen);
    if (rlen == cur_noreply) begin
      return;
    end
    crc = crc_byte(16'h0000, rlen);
    for (int i = 0; i < int'(rlen); i++) begin
      b   = rbyte();
      crc = crc_byte(crc, b);
      maybe_filler(REQ_PRESENCE, REQ_PAYLOAD);
      put_byte(REQ_RX_BYTE, b);
    end
    put_frame_crc(crc, rcrc_ok);
  endtask

  task automatic rand_exchange(input bit allow_cut);
    logic [7:0] plen;
    logic [7:0] rlen;
    logic [7:0] elen;
    logic [9:0] wms;
    plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 20)) : 8'($urandom_range(0, 6));
    wms  = ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'd0;
    rlen = ($urandom_range(0, 9) == 0) ? cur_noreply : 8'($urandom_range(0, 6));
    elen = ($urandom_range(0, 3) == 0) ? rbyte() : rlen;
    ex_budget = (allow_cut && $urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : -1;
    run_exchange(plen, elen, wms, $urandom_range(0, 11) == 0, $urandom_range(0, 7) != 0,
                 rlen, $urandom_range(0, 7) != 0);
    ex_budget = -1;
  endtask

  // random exchanges, the last one always complete so the block ends idle
  task automatic run_random(input int budget);
    int stop_at;
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      rand_exchange(1'b1);
    end
    rand_exchange(1'b0);
    drain();
  endtask

  initial begin : stimulus
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed, reset register values
    run_exchange(8'd2, 8'd1, 10'd0, 1'b1, 1'b1, 8'd0, 1'b1);        // no device
    run_exchange(8'd0, 8'd0, 10'h3FF, 1'b0, 1'b1, 8'd1, 1'b0);      // both reply checks fail
    run_exchange(8'd1, 8'd5, 10'd0, 1'b0, 1'b0, 8'd0, 1'b1);        // bad send crc, checked
    ex_budget = 4;                                                  // longest payload length, cut short
    run_exchange(8'd255, 8'd254, 10'd1, 1'b0, 1'b1, 8'd0, 1'b1);
    ex_budget = -1;
    run_exchange(8'd0, 8'd3, 10'd0, 1'b0, 1'b1, 8'hFF, 1'b1);       // no response
    drain();

    // low extremes, send crc not checked; long result hold-off during a payload
    set_config(1'b0, 8'h00, 8'h00, 8'h00);
    hold_arm <= 1'b1;
    run_exchange(8'd16, 8'd3, 10'd5, 1'b0, 1'b1, 8'd3, 1'b1);
    run_random(PHASE_ITEMS);

    // high extremes, no idling on either side, longest reply
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    set_config(1'b1, 8'hFF, 8'hFF, 8'hFE);
    run_exchange(8'd2, 8'd255, 10'd0, 1'b0, 1'b1, 8'd255, 1'b1);
    run_random(PHASE_ITEMS);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;

    // random register values
    set_config(1'($urandom), rbyte(), rbyte(), rbyte());
    run_random(PHASE_ITEMS);

    // back to the reset values
    set_config(RST_CHECK_CRC, RST_SKIP_ROM, RST_START, RST_NO_REPLY);
    run_random(PHASE_ITEMS);

    $display("covered %0d exchanges: %0d input transactions plus %0d ignored fillers, %0d results",
             n_xchg, n_items, n_filler, checked);
    $display("register sets: reset, all low, all high, random, reset again; one long result stall");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
